@@ sv/pdgr_pkg.sv @@
`default_nettype none
package pdgr_pkg;
   localparam int MaxSelectDef = 16;
   localparam int MaxOrdersDef = 1024;
   localparam int CoordBitsDef = 10;
   localparam logic [9:0] DepotReset = 10'd400;
   localparam logic [4:0] SelectReset = 5'd16;

   localparam logic [1:0] CSR_DEPOT_X = 2'd0;
   localparam logic [1:0] CSR_DEPOT_Y = 2'd1;
   localparam logic [1:0] CSR_SELECT = 2'd2;

   localparam logic [1:0] KIND_SELECTED = 2'd0;
   localparam logic [1:0] KIND_DEPOT = 2'd1;
   localparam logic [1:0] KIND_PICKUP = 2'd2;
   localparam logic [1:0] KIND_DROP = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_SEL_RD,
      ST_SEL_OUT,
      ST_DEPOT_OUT,
      ST_NN_RD,
      ST_NN_CMP,
      ST_STOP_OUT,
      ST_END_OUT
   } state_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [10:0] order_number;
      logic [9:0] point_x;
      logic [9:0] point_y;
      logic last_result;
   } rsp_word_type;

   function automatic logic [11:0] absdiff(input logic [15:0] a, input logic [15:0] b);
      logic [15:0] d;
      d = (a > b) ? a - b : b - a;
      return d[11:0];
   endfunction
endpackage
`default_nettype wire

@@ sv/pdgr_if.sv @@
`default_nettype none
interface pdgr_req_if;
   logic valid;
   logic ready;
   logic [9:0] pickup_x;
   logic [9:0] pickup_y;
   logic [9:0] drop_x;
   logic [9:0] drop_y;
   logic final_order;
   modport source(output valid, pickup_x, pickup_y, drop_x, drop_y, final_order,
                  input ready);
   modport sink(input valid, pickup_x, pickup_y, drop_x, drop_y, final_order,
                output ready);
endinterface

interface pdgr_rsp_if;
   logic valid;
   logic ready;
   logic [1:0] kind;
   logic [10:0] order_number;
   logic [9:0] point_x;
   logic [9:0] point_y;
   logic last_result;
   modport source(output valid, kind, order_number, point_x, point_y, last_result,
                  input ready);
   modport sink(input valid, kind, order_number, point_x, point_y, last_result,
                output ready);
endinterface

interface pdgr_csr_if;
   logic valid;
   logic ready;
   logic [1:0] index;
   logic [9:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ sv/pickup_delivery_greedy_router.sv @@
// Pickup/delivery greedy router.
// Channels: req (one order word per handshake), rsp (result words), csr
// (register writes: index 0 depot_x, 1 depot_y, 2 select_count).
// Each order is scored, then inserted into a sorted list of up to
// MAX_SELECT entries held in registers. Insertion scans the list by cost
// and then shifts the later entries down; a new order is not accepted
// until the previous insertion is done.
// On a final order the block emits the kept order numbers, then the depot,
// then two nearest-neighbor stops per kept order, then the closing depot
// with last_result. Each stop search walks all tasks of the kept orders,
// one compare a cycle, in the single distance unit.
// req.ready and csr.ready are high only in idle; no new order or register
// write is taken during insertion or routing. A stalled rsp holds the
// current word and the sequencer waits. Reset clears the list, masks and
// count; registers return to depot 400,400 and select_count 16.
`default_nettype none
module pickup_delivery_greedy_router
   import pdgr_pkg::*;
#(
   parameter int MAX_SELECT = MaxSelectDef,
   parameter int MAX_ORDERS = MaxOrdersDef
)(
   input wire logic clock,
   input wire logic reset,
   pdgr_req_if.sink req,
   pdgr_rsp_if.source rsp,
   pdgr_csr_if.sink csr
);
   localparam int IW = $clog2(MAX_SELECT) > 0 ? $clog2(MAX_SELECT) : 1;
   localparam int FW = $clog2(MAX_SELECT + 1);
   localparam int TW = $clog2(2 * MAX_SELECT);
   localparam int NT = 2 * MAX_SELECT;
   localparam int CW = $clog2(MAX_ORDERS + 1);

   logic [9:0] depot_x_ff, depot_y_ff;
   logic [4:0] select_ff;
   state_type state_ff, state_in;

   logic [12:0] cost_ff [MAX_SELECT];
   logic [10:0] ord_ff [MAX_SELECT];
   logic [39:0] pts_ff [MAX_SELECT];
   logic [FW-1:0] fill_ff;
   logic [CW-1:0] count_ff;
   logic [NT-1:0] visited_ff, ready_ff;
   logic [9:0] cur_x_ff, cur_y_ff;

   // current order being inserted
   logic [12:0] ncost_ff;
   logic [39:0] npts_ff;
   logic [10:0] nord_ff;
   logic fin_ff, ins_ff;
   logic [FW-1:0] pos_ff, idx_ff;
   logic [TW:0] j_ff, best_ff;
   logic [12:0] bd_ff;
   logic [FW-1:0] n_ff;
   logic [TW:0] step_ff;
   rsp_word_type out_ff;

   // effective K
   logic [FW-1:0] k_eff;
   always_comb begin
      if (select_ff == 5'd0) k_eff = FW'(1);
      else if (32'(select_ff) > MAX_SELECT) k_eff = FW'(MAX_SELECT);
      else k_eff = FW'(select_ff);
   end
   logic [FW-1:0] fill_c;
   assign fill_c = (fill_ff < k_eff) ? fill_ff : k_eff;

   // single distance unit, used by the stop search
   logic [9:0] ua_x, ua_y, ub_x, ub_y;
   logic [12:0] udist;
   assign udist = 13'(absdiff(16'(ua_x), 16'(ub_x))) + 13'(absdiff(16'(ua_y), 16'(ub_y)));

   // task lookup for j_ff
   logic j_drop;
   logic [IW-1:0] j_o;
   logic [9:0] tx, ty;
   always_comb begin
      j_drop = (j_ff >= (TW+1)'(n_ff)) && (j_ff < (TW+1)'(2 * n_ff));
      j_o = j_drop ? IW'(j_ff - (TW+1)'(n_ff)) : IW'(j_ff);
      tx = j_drop ? pts_ff[j_o][19:10] : pts_ff[j_o][39:30];
      ty = j_drop ? pts_ff[j_o][9:0] : pts_ff[j_o][29:20];
   end
   logic [IW-1:0] b_o;
   logic b_drop;
   assign b_drop = best_ff >= (TW+1)'(n_ff);
   assign b_o = b_drop ? IW'(best_ff - (TW+1)'(n_ff)) : IW'(best_ff);

   // one-hot masks of the chosen task and of its delivery
   logic [NT-1:0] best_hot, pair_hot;
   assign best_hot = NT'(1) << best_ff;
   assign pair_hot = best_hot << n_ff;

   assign ua_x = cur_x_ff;
   assign ua_y = cur_y_ff;
   assign ub_x = tx;
   assign ub_y = ty;

   assign req.ready = (state_ff == ST_IDLE);
   assign csr.ready = (state_ff == ST_IDLE);
   logic out_busy;
   assign out_busy = (state_ff == ST_SEL_OUT) || (state_ff == ST_DEPOT_OUT) ||
                     (state_ff == ST_STOP_OUT) || (state_ff == ST_END_OUT);

   // stop word is driven from best_ff, which holds while the stop waits
   rsp_word_type stop_word, rsp_word;
   assign stop_word = '{b_drop ? KIND_DROP : KIND_PICKUP, ord_ff[b_o],
                        b_drop ? pts_ff[b_o][19:10] : pts_ff[b_o][39:30],
                        b_drop ? pts_ff[b_o][9:0] : pts_ff[b_o][29:20], 1'b0};
   assign rsp_word = (state_ff == ST_STOP_OUT) ? stop_word : out_ff;

   assign rsp.valid = out_busy;
   assign rsp.kind = rsp_word.kind;
   assign rsp.order_number = rsp_word.order_number;
   assign rsp.point_x = rsp_word.point_x;
   assign rsp.point_y = rsp_word.point_y;
   assign rsp.last_result = rsp_word.last_result;

   // order cost, computed at accept
   logic [12:0] cost_c;
   always_comb begin
      cost_c = 13'(absdiff(16'(depot_x_ff), 16'(req.pickup_x))) +
               13'(absdiff(16'(depot_y_ff), 16'(req.pickup_y))) +
               13'(absdiff(16'(req.pickup_x), 16'(req.drop_x))) +
               13'(absdiff(16'(req.pickup_y), 16'(req.drop_y))) +
               13'(absdiff(16'(req.drop_x), 16'(depot_x_ff))) +
               13'(absdiff(16'(req.drop_y), 16'(depot_y_ff)));
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req.valid) state_in = ST_SCAN;
         ST_SCAN: begin
            if (!ins_ff) state_in = fin_ff ? ST_SEL_RD : ST_IDLE;
            else if (pos_ff < fill_c && cost_ff[IW'(pos_ff)] <= ncost_ff) state_in = ST_SCAN;
            else state_in = ST_SHIFT;
         end
         ST_SHIFT: if (idx_ff <= pos_ff || pos_ff >= k_eff)
            state_in = fin_ff ? ST_SEL_RD : ST_IDLE;
         ST_SEL_RD: state_in = (idx_ff < n_ff) ? ST_SEL_OUT : ST_DEPOT_OUT;
         ST_SEL_OUT: if (rsp.ready) state_in = ST_SEL_RD;
         ST_DEPOT_OUT: if (rsp.ready) state_in = ST_NN_RD;
         ST_NN_RD: state_in = (step_ff < (TW+1)'(2 * n_ff)) ? ST_NN_CMP : ST_END_OUT;
         ST_NN_CMP: if (j_ff + 1'b1 >= (TW+1)'(2 * n_ff)) state_in = ST_STOP_OUT;
         ST_STOP_OUT: if (rsp.ready) state_in = ST_NN_RD;
         ST_END_OUT: if (rsp.ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         depot_x_ff <= DepotReset;
         depot_y_ff <= DepotReset;
         select_ff <= SelectReset;
         fill_ff <= '0;
         count_ff <= '0;
         visited_ff <= '0;
         ready_ff <= '0;
         cur_x_ff <= DepotReset;
         cur_y_ff <= DepotReset;
      end else begin
         state_ff <= state_in;
         if (csr.valid && csr.ready) begin
            unique case (csr.index)
               CSR_DEPOT_X: depot_x_ff <= csr.data;
               CSR_DEPOT_Y: depot_y_ff <= csr.data;
               CSR_SELECT: select_ff <= csr.data[4:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            ST_IDLE: if (req.valid) begin
               ncost_ff <= cost_c;
               npts_ff <= {req.pickup_x, req.pickup_y, req.drop_x, req.drop_y};
               fin_ff <= req.final_order;
               ins_ff <= (32'(count_ff) < MAX_ORDERS);
               if (32'(count_ff) < MAX_ORDERS) count_ff <= count_ff + 1'b1;
               nord_ff <= 11'(count_ff + 1'b1);
               pos_ff <= '0;
            end
            ST_SCAN: begin
               if (ins_ff && pos_ff < fill_c && cost_ff[IW'(pos_ff)] <= ncost_ff)
                  pos_ff <= pos_ff + 1'b1;
               else if (ins_ff) begin
                  idx_ff <= (fill_c < k_eff) ? fill_c : k_eff - 1'b1;
                  fill_ff <= fill_c;
               end else if (fin_ff) begin
                  idx_ff <= '0;
                  n_ff <= fill_c;
               end
            end
            ST_SHIFT: begin
               if (pos_ff >= k_eff) begin
                  // drop: no room
               end else if (idx_ff > pos_ff) begin
                  cost_ff[IW'(idx_ff)] <= cost_ff[IW'(idx_ff - 1'b1)];
                  ord_ff[IW'(idx_ff)] <= ord_ff[IW'(idx_ff - 1'b1)];
                  pts_ff[IW'(idx_ff)] <= pts_ff[IW'(idx_ff - 1'b1)];
                  idx_ff <= idx_ff - 1'b1;
               end else begin
                  cost_ff[IW'(pos_ff)] <= ncost_ff;
                  ord_ff[IW'(pos_ff)] <= nord_ff;
                  pts_ff[IW'(pos_ff)] <= npts_ff;
                  fill_ff <= (fill_c < k_eff) ? fill_c + 1'b1 : k_eff;
               end
               if (state_in == ST_SEL_RD) begin
                  idx_ff <= '0;
                  n_ff <= (pos_ff >= k_eff) ? fill_c :
                          ((fill_c < k_eff) ? fill_c + 1'b1 : k_eff);
               end
            end
            ST_SEL_RD: begin
               if (idx_ff < n_ff)
                  out_ff <= '{KIND_SELECTED, ord_ff[IW'(idx_ff)], 10'd0, 10'd0, 1'b0};
               else begin
                  out_ff <= '{KIND_DEPOT, 11'd0, depot_x_ff, depot_y_ff, 1'b0};
                  ready_ff <= ~({NT{1'b1}} << n_ff);
                  visited_ff <= '0;
                  cur_x_ff <= depot_x_ff;
                  cur_y_ff <= depot_y_ff;
                  step_ff <= '0;
               end
            end
            ST_SEL_OUT: if (rsp.ready) idx_ff <= idx_ff + 1'b1;
            ST_NN_RD: begin
               j_ff <= '0;
               bd_ff <= '1;
               best_ff <= (TW+1)'(NT);
               out_ff <= '{KIND_DEPOT, 11'd0, depot_x_ff, depot_y_ff, 1'b1};
            end
            ST_NN_CMP: begin
               if (ready_ff[TW'(j_ff)] && !visited_ff[TW'(j_ff)] &&
                   (best_ff == (TW+1)'(NT) || udist < bd_ff)) begin
                  bd_ff <= udist;
                  best_ff <= j_ff;
               end
               j_ff <= j_ff + 1'b1;
            end
            ST_STOP_OUT: begin
               if (rsp.ready) begin
                  visited_ff <= visited_ff | best_hot;
                  ready_ff <= (ready_ff & ~best_hot) | (b_drop ? '0 : pair_hot);
                  cur_x_ff <= b_drop ? pts_ff[b_o][19:10] : pts_ff[b_o][39:30];
                  cur_y_ff <= b_drop ? pts_ff[b_o][9:0] : pts_ff[b_o][29:20];
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_END_OUT: if (rsp.ready) begin
               fill_ff <= '0;
               count_ff <= '0;
               visited_ff <= '0;
               ready_ff <= '0;
               cur_x_ff <= depot_x_ff;
               cur_y_ff <= depot_y_ff;
            end
            default: ;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_fill: assert property (@(posedge clock) disable iff (reset) fill_ff <= FW'(MAX_SELECT))
      else $error("fill overflow");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready) else $error("rsp while idle");
   a_last: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.last_result) |-> state_ff == ST_END_OUT) else $error("bad last");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp_word)))
      else $error("stalled word changed");
`endif
endmodule
`default_nettype wire

@@ tb/pdgr_tb_if.sv @@
`timescale 1ns / 1ps
// Interfaces come from sv/pdgr_if.sv; this file only holds the tb order word type.
package pdgr_tb_types;
   import pdgr_pkg::*;
   typedef struct {
      logic [9:0] px;
      logic [9:0] py;
      logic [9:0] dx;
      logic [9:0] dy;
      logic fin;
   } order_word_type;
endpackage

@@ tb/pickup_delivery_greedy_router_tb.sv @@
`timescale 1ns / 1ps
module pickup_delivery_greedy_router_tb;
   import pdgr_pkg::*;
   import pdgr_tb_types::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pdgr_req_if req ();
   pdgr_rsp_if rsp ();
   pdgr_csr_if csr ();

   pickup_delivery_greedy_router DUT (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source), .csr(csr.sink)
   );

   always #6 clock = ~clock;

   // predictor state
   logic [9:0] depot_x_q, depot_y_q;
   logic [4:0] select_q;
   int unsigned order_cnt;
   int unsigned kept_n;
   int unsigned k_cost [16];
   int unsigned k_ord [16];
   logic [9:0] k_pt [16][4];

   rsp_word_type route_q[$];

   int errors = 0;
   int cycles = 0;
   int src_idle = 0, snk_stall = 0;

   function automatic int unsigned adiff(int unsigned a, int unsigned b);
      return a > b ? a - b : b - a;
   endfunction

   function automatic int unsigned eff_select();
      int unsigned k;
      k = select_q;
      if (k < 1) k = 1;
      if (k > 16) k = 16;
      return k;
   endfunction

   function automatic rsp_word_type mk(logic [1:0] kd, int unsigned o, logic [9:0] x,
                                       logic [9:0] y, logic l);
      rsp_word_type w;
      w.kind = kd; w.order_number = o[10:0]; w.point_x = x; w.point_y = y;
      w.last_result = l;
      return w;
   endfunction

   // queue one expected word at the tail
   function automatic void add_exp(input rsp_word_type w);
      route_q.insert(route_q.size(), w);
   endfunction

   // score and insert one order, then route on the final flag
   task automatic predict_order(input order_word_type o);
      int unsigned k, cost, fill, pos, i, n, best, bd, d, j, t, cx, cy, tx, ty;
      bit vis [32];
      bit rdy [32];
      if (order_cnt < 1024) begin
         order_cnt++;
         k = eff_select();
         cost = adiff(depot_x_q, o.px) + adiff(depot_y_q, o.py)
              + adiff(o.px, o.dx) + adiff(o.py, o.dy)
              + adiff(o.dx, depot_x_q) + adiff(o.dy, depot_y_q);
         fill = kept_n < k ? kept_n : k;
         pos = 0;
         while (pos < fill && k_cost[pos] <= cost) pos++;
         if (pos >= k) begin
            kept_n = fill;
         end else begin
            for (i = (fill < k) ? fill : k - 1; i > pos; i--) begin
               k_cost[i] = k_cost[i-1]; k_ord[i] = k_ord[i-1];
               for (t = 0; t < 4; t++) k_pt[i][t] = k_pt[i-1][t];
            end
            k_cost[pos] = cost; k_ord[pos] = order_cnt;
            k_pt[pos][0] = o.px; k_pt[pos][1] = o.py;
            k_pt[pos][2] = o.dx; k_pt[pos][3] = o.dy;
            kept_n = (fill < k) ? fill + 1 : k;
         end
      end
      if (!o.fin) return;
      k = eff_select();
      n = kept_n < k ? kept_n : k;
      for (i = 0; i < n; i++) add_exp(mk(KIND_SELECTED, k_ord[i], 10'd0, 10'd0, 1'b0));
      for (i = 0; i < 32; i++) begin
         vis[i] = 0; rdy[i] = (i < n);
      end
      cx = depot_x_q; cy = depot_y_q;
      add_exp(mk(KIND_DEPOT, 0, depot_x_q, depot_y_q, 1'b0));
      for (i = 0; i < 2 * n; i++) begin
         best = 32; bd = 32'hFFFF_FFFF;
         for (j = 0; j < 2 * n; j++) begin
            if (rdy[j] && !vis[j]) begin
               t = j < n ? j : j - n;
               tx = j < n ? k_pt[t][0] : k_pt[t][2];
               ty = j < n ? k_pt[t][1] : k_pt[t][3];
               d = adiff(cx, tx) + adiff(cy, ty);
               if (d < bd) begin
                  bd = d; best = j;
               end
            end
         end
         t = best < n ? best : best - n;
         tx = best < n ? k_pt[t][0] : k_pt[t][2];
         ty = best < n ? k_pt[t][1] : k_pt[t][3];
         vis[best] = 1; rdy[best] = 0;
         if (best < n) rdy[best + n] = 1;
         cx = tx; cy = ty;
         add_exp(mk(best < n ? KIND_PICKUP : KIND_DROP, k_ord[t], 10'(tx), 10'(ty), 1'b0));
      end
      add_exp(mk(KIND_DEPOT, 0, depot_x_q, depot_y_q, 1'b1));
      order_cnt = 0;
      kept_n = 0;
   endtask

   // directed table: expected words typed in only for the trivial single order
   order_word_type dir_tab [$];
   rsp_word_type dir_exp [$];

   initial begin
      req.valid = 0; req.pickup_x = 0; req.pickup_y = 0; req.drop_x = 0;
      req.drop_y = 0; req.final_order = 0;
      csr.valid = 0; csr.index = CSR_DEPOT_X; csr.data = 0;
      rsp.ready = 0;
      depot_x_q = DepotReset; depot_y_q = DepotReset; select_q = SelectReset;
      order_cnt = 0; kept_n = 0;
   end

   // cycle limit for the whole run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 2_000_000) begin
         $display("Verification failed");
         $finish;
      end
   end

   // receiver: stall per phase, check each accepted word
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp.valid && rsp.ready) begin
            if (route_q.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected word kind=%0d ord=%0d",
                                          rsp.kind, rsp.order_number);
            end else begin
               rsp_word_type e;
               e = route_q.pop_front();
               if (rsp.kind !== e.kind || rsp.order_number !== e.order_number ||
                   rsp.point_x !== e.point_x || rsp.point_y !== e.point_y ||
                   rsp.last_result !== e.last_result) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch exp %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                        e.kind, e.order_number, e.point_x, e.point_y, e.last_result,
                        rsp.kind, rsp.order_number, rsp.point_x, rsp.point_y,
                        rsp.last_result);
               end
            end
         end
         rsp.ready <= ($urandom_range(99) >= snk_stall);
      end
   end

   task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
      csr.valid <= 1; csr.index <= idx; csr.data <= val;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 0;
      case (idx)
         CSR_DEPOT_X: depot_x_q = val;
         CSR_DEPOT_Y: depot_y_q = val;
         CSR_SELECT: select_q = val[4:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // drive one order word, idling first as the phase asks
   task automatic send_order(input order_word_type o);
      while ($urandom_range(99) < src_idle) @(posedge clock);
      req.valid <= 1; req.pickup_x <= o.px; req.pickup_y <= o.py;
      req.drop_x <= o.dx; req.drop_y <= o.dy; req.final_order <= o.fin;
      do @(posedge clock); while (!req.ready);
      predict_order(o);
      req.valid <= 0;
      @(posedge clock);
   endtask

   // drain results and let the sequencer settle before a register write
   task automatic drain();
      int n;
      n = 0;
      while (route_q.size() != 0) @(posedge clock);
      while (n < 80) begin
         @(posedge clock); n++;
      end
   endtask

   function automatic order_word_type rnd_order(input bit fin);
      order_word_type o;
      int m;
      m = $urandom_range(3);
      o.px = 10'((m == 0) ? $urandom_range(1023) : $urandom_range(380, 420));
      o.py = 10'((m == 0) ? $urandom_range(1023) : $urandom_range(380, 420));
      o.dx = 10'((m == 1) ? $urandom_range(1023) : $urandom_range(380, 420));
      o.dy = 10'((m == 1) ? $urandom_range(1023) : $urandom_range(380, 420));
      o.fin = fin;
      return o;
   endfunction

   initial begin
      order_word_type o;
      int sent, setlen, j, ph;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // single order at reset settings: depot, pickup, drop, depot
      o = '{10'd0, 10'd1023, 10'd1023, 10'd0, 1'b1};
      dir_tab = '{o};
      send_order(o);
      dir_exp = '{mk(KIND_SELECTED, 1, 10'd0, 10'd0, 1'b0),
                  mk(KIND_DEPOT, 0, 10'd400, 10'd400, 1'b0),
                  mk(KIND_PICKUP, 1, 10'd0, 10'd1023, 1'b0),
                  mk(KIND_DROP, 1, 10'd1023, 10'd0, 1'b0),
                  mk(KIND_DEPOT, 0, 10'd400, 10'd400, 1'b1)};
      foreach (dir_exp[i]) begin
         if (route_q[i] !== dir_exp[i]) begin
            errors++;
            if (errors <= 10) $display("directed table row %0d disagrees", i);
         end
      end
      drain();

      // directed table: ties, all-zero/all-ones coordinates, select=1 with cut
      dir_tab = '{'{10'd400, 10'd400, 10'd400, 10'd400, 1'b0},
                  '{10'd0, 10'd0, 10'd0, 10'd0, 1'b0},
                  '{10'd1023, 10'd1023, 10'd1023, 10'd1023, 1'b0},
                  '{10'd410, 10'd400, 10'd390, 10'd400, 1'b0},
                  '{10'd390, 10'd400, 10'd410, 10'd400, 1'b0},
                  '{10'd400, 10'd400, 10'd400, 10'd400, 1'b1}};
      foreach (dir_tab[i]) send_order(dir_tab[i]);
      drain();
      write_reg(CSR_SELECT, 10'd1);
      write_reg(CSR_DEPOT_X, 10'd0);
      write_reg(CSR_DEPOT_Y, 10'd1023);
      foreach (dir_tab[i]) send_order(dir_tab[i]);
      drain();
      // select 0 acts as one, 31 as the maximum
      write_reg(CSR_SELECT, 10'd0);
      foreach (dir_tab[i]) send_order(dir_tab[i]);
      drain();
      write_reg(CSR_SELECT, 10'd31);
      write_reg(CSR_DEPOT_X, 10'd1023);
      write_reg(CSR_DEPOT_Y, 10'd0);

      // random sets across idling phases
      sent = 0;
      for (ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin src_idle = 0; snk_stall = 0; end
            1: begin src_idle = 54; snk_stall = 0; end
            2: begin src_idle = 0; snk_stall = 54; end
            default: begin src_idle = 24; snk_stall = 24; end
         endcase
         repeat (4) begin
            setlen = ($urandom_range(7) == 0) ? $urandom_range(20, 30)
                                              : $urandom_range(1, 8);
            for (j = 0; j < setlen; j++) begin
               send_order(rnd_order(j == setlen - 1));
               sent++;
            end
            // hold the next set until every result word has arrived
            drain();
            write_reg(CSR_DEPOT_X, 10'($urandom_range(1023)));
            write_reg(CSR_DEPOT_Y, 10'($urandom_range(1023)));
            write_reg(CSR_SELECT, 10'($urandom_range(31)));
         end
      end
      // select changed mid-set: write while idle between orders
      src_idle = 0; snk_stall = 10;
      while (sent < 400) begin
         write_reg(CSR_SELECT, 10'($urandom_range(2, 16)));
         for (j = 0; j < 6; j++) send_order(rnd_order(0));
         write_reg(CSR_SELECT, 10'($urandom_range(1, 6)));
         for (j = 0; j < 4; j++) send_order(rnd_order(j == 3));
         sent += 10;
         drain();
      end
      if (errors == 0 && route_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
